>>> sv/hsv2rgb_pkg.sv
// ============================================================================
// hsv2rgb_pkg
// Shared constants for the HSV to RGB color converter.
// ============================================================================
package hsv2rgb_pkg;

    // Default number of fraction bits in the internal fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Input field width (hue, saturation, brightness).
    localparam int IN_W  = 16;
    // Output channel width.
    localparam int OUT_W = 8;
    // Full-scale output channel value.
    localparam logic [OUT_W-1:0] CHAN_MAX = 8'd255;

    // Hue sector codes (integer part of hue * 6).
    localparam logic [2:0] SECT_RED_YEL = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG = 3'd4;
    localparam logic [2:0] SECT_MAG_RED = 3'd5;

endpackage

>>> sv/hsv_to_rgb_converter.sv
// ============================================================================
// hsv_to_rgb_converter
// Five-stage pipelined HSV to RGB pixel converter in unsigned fixed point.
// ============================================================================
// Usage:
//   A pixel transaction (hue, saturation, brightness) is taken at a rising
//   edge where start is high and busy is low. busy is always low: the
//   pipeline never stalls, so a new pixel may enter on every clock.
//   Each result (red, green, blue) is on the outputs for one cycle with done
//   high and is taken at the edge that ends that cycle. The receiver cannot
//   hold results off, and none is needed: nothing here backs up.
// Pipeline / throughput:
//   Each pixel passes five registered stages: scale inputs, two s*f
//   products, term select, v*term, scale by 255. Throughput is one pixel
//   per clock.
// Reset:
//   rst_n (async, active low) clears the valid bits of every stage, so no
//   result is issued for pixels in flight. Data registers are not reset.
// Fixed point:
//   ONE = 2**FRAC_BITS stands for 1.0; saturation and brightness are scaled
//   as floor(x * ONE / 65535) by a fold-and-correct on the 65535 divisor.
// ============================================================================
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hsv2rgb_pkg::IN_W-1:0]  hue,
    input  logic [hsv2rgb_pkg::IN_W-1:0]  saturation,
    input  logic [hsv2rgb_pkg::IN_W-1:0]  brightness,
    output logic                          done,
    output logic [hsv2rgb_pkg::OUT_W-1:0] red,
    output logic [hsv2rgb_pkg::OUT_W-1:0] green,
    output logic [hsv2rgb_pkg::OUT_W-1:0] blue
);

    localparam int IW  = hsv2rgb_pkg::IN_W;
    localparam int OW  = hsv2rgb_pkg::OUT_W;
    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 1;                       // holds 0..ONE
    localparam int SW  = ((F > IW) ? F : IW) + 1;     // first fold sum
    localparam int CW  = 2 * QW + OW - 2 * F;         // scaled channel width
    localparam logic [QW-1:0] ONE = QW'(1) << F;
    localparam logic [IW:0]   DIV = {1'b0, {IW{1'b1}}};

    // floor(x * ONE / 65535): y = a*65536 + b = a*65535 + (a + b), folded twice
    function automatic logic [QW-1:0] unit_to_q(input logic [IW-1:0] x);
        logic [IW+F-1:0] y;
        logic [F-1:0]    a;
        logic [SW-1:0]   sum1;
        logic [SW-IW-1:0] a2;
        logic [IW:0]     sum2;
        logic            corr;
        y    = {x, {F{1'b0}}};
        a    = y[IW+F-1:IW];
        sum1 = SW'(a) + SW'(y[IW-1:0]);
        a2   = sum1[SW-1:IW];
        sum2 = (IW+1)'(a2) + {1'b0, sum1[IW-1:0]};
        corr = (sum2 >= DIV);
        return QW'(a) + QW'(a2) + QW'(corr);
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: sector / fraction, scale s and v
    // ------------------------------------------------------------------
    logic [IW+2:0] h6;
    logic [23:0]   frac_wide;
    logic          v1_reg;
    logic [2:0]    sect1_reg, sect1_next;
    logic [F-1:0]  f1_reg, f1_next;
    logic [QW-1:0] s1_reg, s1_next;
    logic [QW-1:0] val1_reg, val1_next;

    always_comb
    begin
        h6         = {2'b00, hue, 1'b0} + {1'b0, hue, 2'b00};
        sect1_next = h6[IW+2:IW];
        frac_wide  = {h6[IW-1:0], 8'h00} >> (24 - F);
        f1_next    = frac_wide[F-1:0];
        s1_next    = unit_to_q(saturation);
        val1_next  = unit_to_q(brightness);
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            sect1_reg <= sect1_next;
            f1_reg    <= f1_next;
            s1_reg    <= s1_next;
            val1_reg  <= val1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: s*f and s*(1-f)
    // ------------------------------------------------------------------
    logic              v2_reg;
    logic [2:0]        sect2_reg;
    logic              gray2_reg, gray2_next;
    logic [QW-1:0]     p2_reg, p2_next;
    logic [QW-1:0]     val2_reg;
    logic [QW+F-1:0]   sf2_reg, sf2_next;
    logic [2*QW-1:0]   sg2_reg, sg2_next;

    always_comb
    begin
        gray2_next = (s1_reg == '0);
        p2_next    = ONE - s1_reg;
        sf2_next   = s1_reg * f1_reg;
        sg2_next   = s1_reg * (ONE - QW'(f1_reg));
    end

    always_ff @(posedge clk)
    begin
        sect2_reg <= sect1_reg;
        gray2_reg <= gray2_next;
        p2_reg    <= p2_next;
        val2_reg  <= val1_reg;
        sf2_reg   <= sf2_next;
        sg2_reg   <= sg2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: q, t and per-sector term select
    // ------------------------------------------------------------------
    logic          v3_reg;
    logic [QW-1:0] q3, t3;
    logic [QW-1:0] tr3_reg, tr3_next;
    logic [QW-1:0] tg3_reg, tg3_next;
    logic [QW-1:0] tb3_reg, tb3_next;
    logic [QW-1:0] val3_reg;

    always_comb
    begin
        q3       = ONE - sf2_reg[QW+F-1:F];
        t3       = ONE - sg2_reg[QW+F-1:F];
        tr3_next = ONE;
        tg3_next = ONE;
        tb3_next = ONE;
        if (!gray2_reg)
        begin
            unique case (sect2_reg)
                hsv2rgb_pkg::SECT_YEL_GRN:
                begin
                    tr3_next = q3;
                    tb3_next = p2_reg;
                end
                hsv2rgb_pkg::SECT_GRN_CYN:
                begin
                    tr3_next = p2_reg;
                    tb3_next = t3;
                end
                hsv2rgb_pkg::SECT_CYN_BLU:
                begin
                    tr3_next = p2_reg;
                    tg3_next = q3;
                end
                hsv2rgb_pkg::SECT_BLU_MAG:
                begin
                    tr3_next = t3;
                    tg3_next = p2_reg;
                end
                hsv2rgb_pkg::SECT_MAG_RED:
                begin
                    tg3_next = p2_reg;
                    tb3_next = q3;
                end
                default:
                begin
                    // red-yellow sector; unused codes land here too
                    tg3_next = t3;
                    tb3_next = p2_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tr3_reg  <= tr3_next;
        tg3_reg  <= tg3_next;
        tb3_reg  <= tb3_next;
        val3_reg <= val2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: v * term
    // ------------------------------------------------------------------
    logic            v4_reg;
    logic [2*QW-1:0] mr4_reg, mg4_reg, mb4_reg;

    always_ff @(posedge clk)
    begin
        mr4_reg <= val3_reg * tr3_reg;
        mg4_reg <= val3_reg * tg3_reg;
        mb4_reg <= val3_reg * tb3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: times 255, drop 2F fraction bits, clamp
    // ------------------------------------------------------------------
    function automatic logic [OW-1:0] scale_chan(input logic [2*QW-1:0] m);
        logic [2*QW+OW-1:0] m255;
        logic [CW-1:0]      c;
        m255 = {m, {OW{1'b0}}} - (2*QW+OW)'(m);
        c    = m255[2*QW+OW-1:2*F];
        return (c > CW'(hsv2rgb_pkg::CHAN_MAX)) ? hsv2rgb_pkg::CHAN_MAX : c[OW-1:0];
    endfunction

    logic          done_reg;
    logic [OW-1:0] red_reg, red_next;
    logic [OW-1:0] green_reg, green_next;
    logic [OW-1:0] blue_reg, blue_next;

    always_comb
    begin
        red_next   = scale_chan(mr4_reg);
        green_next = scale_chan(mg4_reg);
        blue_next  = scale_chan(mb4_reg);
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted pixel did not produce a result after 5 cycles");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(saturation, 5) == '0)) |-> ((red == green) && (green == blue)))
        else $error("zero saturation did not give equal channels");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(brightness, 5) == '0)) |->
            ((red == '0) && (green == '0) && (blue == '0)))
        else $error("zero brightness did not give black");

endmodule

>>> tb/sv/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_hsv_to_rgb_converter
// Self-checking bench for the HSV to RGB pixel converter.
// ============================================================================
// A table of directed pixels runs first: grey levels, pure hues, the six
// sectors and the edges between them. A long random stream follows. Pixels
// are sent in bursts with random gaps. Each accepted pixel's expected color
// comes from the table or a fixed-point predictor and goes into a queue.
// Every done strobe is checked field by field against the oldest queued
// color. A watchdog ends the run if no transaction moves for too long.
// ============================================================================
module tb_hsv_to_rgb_converter;

    localparam int IN_W           = hsv2rgb_pkg::IN_W;
    localparam int OUT_W          = hsv2rgb_pkg::OUT_W;
    localparam int FRAC           = hsv2rgb_pkg::FRAC_BITS_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_LATENCY   = 5;
    localparam int RANDOM_PIXELS  = 1500;
    localparam int MAX_GAP        = 8;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_ROWS       = 25;

    localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

    typedef struct packed {
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] g;
        logic [OUT_W-1:0] b;
    } rgb_t;

    // One directed pixel. Where "typed" is set the color below is the
    // expected one; otherwise the predictor decides.
    typedef struct packed {
        logic [IN_W-1:0] h;
        logic [IN_W-1:0] s;
        logic [IN_W-1:0] v;
        logic            typed;
        rgb_t            want;
    } pixel_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [IN_W-1:0] hue = '0;
    logic [IN_W-1:0] saturation = '0;
    logic [IN_W-1:0] brightness = '0;
    logic            done;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;

    // Typed expectation travels with the pixel on the input side.
    logic row_typed = 1'b0;
    rgb_t row_want = '0;

    rgb_t pending_rgb_q[$];
    int   fail_count = 0;
    int   idle_cycles = 0;

    pixel_row_t directed_rows [NUM_ROWS] = '{
        // grey axis: saturation zero, hue ignored
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'h0000, 16'h0000, 16'h8000, 1'b1, '{8'd127, 8'd127, 8'd127}},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
        // pure red and cyan at full saturation and value, then red at zero value
        '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        // smallest nonzero value and saturation
        '{16'h0000, 16'hFFFF, 16'h0001, 1'b0, '0},
        '{16'h0000, 16'h0001, 16'hFFFF, 1'b0, '0},
        // middle of each sector
        '{16'h1555, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h4000, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h6AAB, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h9555, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hC000, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hEAAB, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        // hue extremes and sector edges
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h2AAA, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h2AAB, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h5556, 16'h8000, 16'hC000, 1'b0, '0},
        '{16'hAAAB, 16'h8000, 16'hFFFF, 1'b0, '0},
        '{16'hD555, 16'hFFFF, 16'h8000, 1'b0, '0},
        '{16'hD556, 16'h4000, 16'hFFFF, 1'b0, '0},
        '{16'h7FFF, 16'hFFFE, 16'hFFFE, 1'b0, '0},
        '{16'h3333, 16'h7FFF, 16'h1234, 1'b0, '0}
    };

    hsv_to_rgb_converter #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------------

    // v * term * 255 over ONE^2, one truncation, clamped to a byte.
    function automatic logic [OUT_W-1:0] scale_channel(logic [63:0] v, logic [63:0] term);
        logic [63:0] c;
        c = ((v * term) * 64'd255) >> (2 * FRAC);
        if (c > 64'd255)
            c = 64'd255;
        return c[OUT_W-1:0];
    endfunction

    function automatic rgb_t predict_rgb(logic [IN_W-1:0] h_in, logic [IN_W-1:0] s_in,
                                         logic [IN_W-1:0] v_in);
        logic [63:0] s_q;
        logic [63:0] v_q;
        logic [63:0] h6;
        logic [63:0] frac;
        logic [63:0] p_t;
        logic [63:0] q_t;
        logic [63:0] t_t;
        logic [63:0] tr;
        logic [63:0] tg;
        logic [63:0] tb;
        logic [2:0]  sector;
        rgb_t        o;
        // 65535 maps to exactly ONE
        s_q = ({48'd0, s_in} * ONE_Q) / 64'd65535;
        v_q = ({48'd0, v_in} * ONE_Q) / 64'd65535;
        tr  = ONE_Q;
        tg  = ONE_Q;
        tb  = ONE_Q;
        if (s_q != 64'd0) begin
            h6     = {48'd0, h_in} * 64'd6;
            sector = h6[18:16];
            frac   = ((h6 & 64'hFFFF) << 8) >> (24 - FRAC);
            p_t    = ONE_Q - s_q;
            q_t    = ONE_Q - ((s_q * frac) >> FRAC);
            t_t    = ONE_Q - ((s_q * (ONE_Q - frac)) >> FRAC);
            case (sector)
                hsv2rgb_pkg::SECT_YEL_GRN: begin tr = q_t; tb = p_t; end
                hsv2rgb_pkg::SECT_GRN_CYN: begin tr = p_t; tb = t_t; end
                hsv2rgb_pkg::SECT_CYN_BLU: begin tr = p_t; tg = q_t; end
                hsv2rgb_pkg::SECT_BLU_MAG: begin tr = t_t; tg = p_t; end
                hsv2rgb_pkg::SECT_MAG_RED: begin tg = p_t; tb = q_t; end
                default:                   begin tg = t_t; tb = p_t; end
            endcase
        end
        o.r = scale_channel(v_q, tr);
        o.g = scale_channel(v_q, tg);
        o.b = scale_channel(v_q, tb);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Random field values, biased toward the corners
    // ------------------------------------------------------------------------

    function automatic logic [IN_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return IN_W'($urandom_range(1, 3));
            3:       return IN_W'($urandom_range(65532, 65535));
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Hue: plain random most of the time, else a few codes around a sector edge.
    function automatic logic [IN_W-1:0] rand_hue();
        int k;
        int delta;
        if ($urandom_range(0, 3) != 0)
            return IN_W'($urandom);
        k     = $urandom_range(0, 5);
        delta = $urandom_range(0, 4) - 2;
        return IN_W'((k * 65536 + 5) / 6 + delta);
    endfunction

    // ------------------------------------------------------------------------
    // Failure bookkeeping: first few are printed, the rest only counted
    // ------------------------------------------------------------------------

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks results first, then queues the color for a new pixel.
    // A result comes through registers, so the order never matters in one edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        rgb_t want_rgb;
        rgb_t got_rgb;
        if (rst_n) begin
            got_rgb = '{red, green, blue};
            if (done) begin
                if (pending_rgb_q.size() == 0) begin
                    note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                           red, green, blue));
                end else begin
                    want_rgb = pending_rgb_q.pop_front();
                    if (got_rgb.r !== want_rgb.r || got_rgb.g !== want_rgb.g ||
                        got_rgb.b !== want_rgb.b)
                        note_failure($sformatf(
                            "color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                            want_rgb.r, want_rgb.g, want_rgb.b, red, green, blue));
                end
            end
            if (start && !busy)
                pending_rgb_q.push_back(row_typed ? row_want
                                                  : predict_rgb(hue, saturation, brightness));

            // watchdog: any moving transaction clears it
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("hsv_to_rgb_converter test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side: one assignment per signal per falling edge
    // ------------------------------------------------------------------------

    // Present a pixel and hold it until the block takes it.
    task automatic send_pixel(logic [IN_W-1:0] h, logic [IN_W-1:0] s, logic [IN_W-1:0] v,
                              logic typed, rgb_t want);
        @(negedge clk);
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Gap with junk on the data ports; the block must ignore it.
    task automatic idle_for(int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start      <= 1'b0;
            hue        <= IN_W'($urandom);
            saturation <= IN_W'($urandom);
            brightness <= IN_W'($urandom);
            row_typed  <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int sent;
        int burst;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_for(2);

        // directed table; back to back, with about a quarter of rows followed by an idle gap
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].h, directed_rows[i].s, directed_rows[i].v,
                       directed_rows[i].typed, directed_rows[i].want);
            if ($urandom_range(0, 3) == 0)
                idle_for(1);
        end

        // random bursts; about a quarter run straight into the next burst
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 40);
            for (int n = 0; n < burst && sent < RANDOM_PIXELS; n++) begin
                send_pixel(rand_hue(), rand_level(), rand_level(), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, MAX_GAP));
        end
        idle_for(1);

        // drain, then let the pipeline settle to catch stray strobes
        while (pending_rgb_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);

        if (pending_rgb_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_rgb_q.size()));

        if (fail_count == 0)
            $display("hsv_to_rgb_converter test passed");
        else
            $display("hsv_to_rgb_converter test failed");
        $finish;
    end

endmodule
